FILE: rtl/core/knn_pkg.sv
package knn_pkg;

    localparam int NUM_FEATURES = 40;
    localparam int DB_DEPTH     = 1024;
    localparam int MAX_K        = 16;
    localparam int NUM_CLASSES  = 100;
    localparam int QUEUE_DEPTH  = 4;

    localparam int ACT_W  = 2;
    localparam int VAL_W  = 16;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 2;
    localparam int CLS_W  = 7;
    localparam int NC_W   = 5;

    localparam int F_W   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int POS_W = $clog2(NUM_FEATURES + 1);
    localparam int E_W   = (DB_DEPTH > 1) ? $clog2(DB_DEPTH) : 1;
    localparam int T_W   = $clog2(DB_DEPTH + 1);
    localparam int A_W   = (DB_DEPTH * NUM_FEATURES > 1) ? $clog2(DB_DEPTH * NUM_FEATURES) : 1;
    localparam int K_W   = $clog2(MAX_K + 1);
    localparam int KI_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int Q_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

    localparam int DIFF_W = VAL_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int TERM_W = SQ_W + VAL_W;
    localparam int DIST_W = 56;

    localparam logic [DIST_W-1:0] DIST_TOP   = '1;
    localparam logic [VAL_W-1:0]  WEIGHT_ONE = VAL_W'(256);

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_NO_DB,
        ST_RANGE,
        ST_FULL
    } status_t;

    typedef enum logic [ACT_W-1:0] {
        OP_FEAT,
        OP_CLEAR,
        OP_READ,
        OP_WEIGHT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic             last;
        logic             w_ok;
    } cmd_t;

    typedef struct packed {
        logic [K_W-1:0]   k;
        logic             learn_en;
        logic [CLS_W-1:0] learn_class;
    } cfg_t;

endpackage

FILE: rtl/core/knn_front.sv
module knn_front
    import knn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [ACT_W-1:0]        action,
    input  logic signed [VAL_W-1:0] value,
    input  logic [IDX_W-1:0]        index,
    input  logic                    last,
    input  logic                    pop,
    output logic                    cmd_valid,
    output cmd_t                    cmd
);

    cmd_t             q_mem [QUEUE_DEPTH];
    logic [Q_W-1:0]   wr_ptr_reg;
    logic [Q_W-1:0]   rd_ptr_reg;
    logic [QC_W-1:0]  count_reg;
    logic             push;
    cmd_t             dec;

    // decode the incoming item
    always_comb
    begin
        dec.op    = op_t'(action);
        dec.value = value;
        dec.index = index;
        dec.last  = last;
        dec.w_ok  = (32'(index) < NUM_FEATURES);
    end

    assign in_stall  = (count_reg == QC_W'(QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QC_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QC_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cmd_valid)
        else $error("pop from empty queue");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + QC_W'(1)))
        else $error("queue count did not follow push");

endmodule

FILE: rtl/core/knn_back.sv
module knn_back
    import knn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     cmd_valid,
    input  cmd_t                     cmd,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic [CLS_W-1:0]         class_id,
    output logic signed [VAL_W-1:0]  feature_value,
    output logic                     end_of_run
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEARN,
        S_SEARCH,
        S_VREAD,
        S_VCOUNT,
        S_RD_ISSUE,
        S_RD_WAIT
    } state_t;

    state_t state_reg;

    // stores
    logic [VAL_W-1:0] qmem   [NUM_FEATURES];
    logic [VAL_W-1:0] wmem   [NUM_FEATURES];
    logic [VAL_W-1:0] dbf_mem [DB_DEPTH * NUM_FEATURES];
    logic [CLS_W-1:0] dbc_mem [DB_DEPTH];
    logic [NUM_FEATURES-1:0] qvalid_reg;
    logic [NUM_FEATURES-1:0] wvalid_reg;
    logic [VAL_W-1:0] q_rd_reg;
    logic [VAL_W-1:0] w_rd_reg;
    logic             qv_rd_reg;
    logic             wv_rd_reg;
    logic [VAL_W-1:0] dbf_rd_reg;
    logic [CLS_W-1:0] dbc_rd_reg;

    // sequencing
    logic [T_W-1:0]   total_reg;
    logic [POS_W-1:0] pos_reg;
    logic [F_W-1:0]   f_reg;
    logic [A_W-1:0]   addr_reg;
    logic [E_W-1:0]   ent_reg;
    logic             issue_done_reg;

    // learn copy
    logic             lw_v_reg;
    logic             lw_last_reg;
    logic [A_W-1:0]   lw_addr_reg;

    // distance pipeline
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic             t1_last_reg, t2_last_reg, t3_last_reg;
    logic [E_W-1:0]   t1_ent_reg, t2_ent_reg, t3_ent_reg, t4_ent_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [VAL_W-1:0] w2_reg;
    logic [TERM_W-1:0] term_reg;
    logic [DIST_W-1:0] acc_reg;
    logic [DIST_W-1:0] dist_reg;

    // k-best list and vote
    logic [DIST_W-1:0] best_dist_reg [MAX_K];
    logic [E_W-1:0]    best_ent_reg  [MAX_K];
    logic [CLS_W-1:0]  vcls_reg      [MAX_K];
    logic [K_W-1:0]    vi_reg;
    logic              vr_v_reg;
    logic [KI_W-1:0]   vr_idx_reg;
    logic [K_W-1:0]    top_reg;
    logic [CLS_W-1:0]  win_reg;

    // result register
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [CLS_W-1:0]  out_class_reg;
    logic [VAL_W-1:0]  out_feat_reg;
    logic              out_eor_reg;

    logic              out_free;
    logic              out_load;
    status_t           ld_status;
    logic [CLS_W-1:0]  ld_class;
    logic [VAL_W-1:0]  ld_feat;
    logic              ld_eor;

    logic              last_f;
    logic              last_ent;
    logic              full;
    logic              rd_ok;
    logic [A_W-1:0]    rd_base;
    logic [A_W-1:0]    learn_base;
    logic [K_W-1:0]    k_last;
    logic              search_start;
    logic              q_we;
    logic              w_we;
    logic              dbc_we;
    logic [E_W-1:0]    dbc_raddr;
    logic [VAL_W-1:0]  q_eff;
    logic [VAL_W-1:0]  d_eff;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] mag;
    logic [DIST_W-1:0] acc_sum;

    logic [MAX_K-1:0]  lt;
    logic [DIST_W-1:0] ins_dist [MAX_K];
    logic [E_W-1:0]    ins_ent  [MAX_K];

    logic [CLS_W-1:0]  cand;
    logic [K_W-1:0]    cnt;
    logic              better;
    logic              vote_last;

    assign out_free   = !out_valid_reg || !out_stall;
    assign pop        = (state_reg == S_IDLE) && cmd_valid && out_free;
    assign last_f     = (f_reg == F_W'(NUM_FEATURES - 1));
    assign last_ent   = (32'(ent_reg) == 32'(total_reg) - 32'd1);
    assign full       = (total_reg == T_W'(DB_DEPTH));
    assign rd_ok      = (32'(cmd.index) < 32'(total_reg));
    assign rd_base    = A_W'(32'(cmd.index) * NUM_FEATURES);
    assign learn_base = A_W'(32'(total_reg) * NUM_FEATURES);
    assign k_last     = cfg.k - K_W'(1);

    assign search_start = pop && (cmd.op == OP_FEAT) && cmd.last && !cfg.learn_en
                          && (total_reg != '0);
    assign q_we   = pop && (cmd.op == OP_FEAT) && (pos_reg < POS_W'(NUM_FEATURES));
    assign w_we   = pop && (cmd.op == OP_WEIGHT) && cmd.w_ok;
    assign dbc_we = (state_reg == S_LEARN) && lw_v_reg && lw_last_reg;
    assign dbc_raddr = (state_reg == S_VREAD) ? best_ent_reg[vi_reg[KI_W-1:0]] : ent_reg;

    // difference magnitude
    assign q_eff = qv_rd_reg ? q_rd_reg : '0;
    assign d_eff = dbf_rd_reg;
    assign diff  = $signed({q_eff[VAL_W-1], q_eff}) - $signed({d_eff[VAL_W-1], d_eff});
    assign mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign acc_sum = acc_reg + DIST_W'(term_reg);

    // sorted insertion: new entry goes before the first strictly larger slot
    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            lt[i] = (i < 32'(cfg.k)) && (dist_reg < best_dist_reg[i]);
        end
        for (int i = 0; i < MAX_K; i++)
        begin
            ins_dist[i] = best_dist_reg[i];
            ins_ent[i]  = best_ent_reg[i];
            if (lt[i])
            begin
                if (i > 0 && lt[i-1])
                begin
                    ins_dist[i] = best_dist_reg[i-1];
                    ins_ent[i]  = best_ent_reg[i-1];
                end
                else
                begin
                    ins_dist[i] = dist_reg;
                    ins_ent[i]  = t4_ent_reg;
                end
            end
        end
    end

    // one candidate class per cycle, count its votes
    always_comb
    begin
        cand = vcls_reg[vi_reg[KI_W-1:0]];
        cnt  = '0;
        for (int j = 0; j < MAX_K; j++)
        begin
            if ((j < 32'(cfg.k)) && (vcls_reg[j] == cand))
            begin
                cnt = cnt + K_W'(1);
            end
        end
        better    = (32'(cand) < NUM_CLASSES)
                    && ((cnt > top_reg) || ((cnt == top_reg) && (cand < win_reg)));
        vote_last = (vi_reg == k_last);
    end

    // result selection
    always_comb
    begin
        out_load  = 1'b0;
        ld_status = ST_OK;
        ld_class  = '0;
        ld_feat   = '0;
        ld_eor    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    case (cmd.op)
                        OP_FEAT:
                        begin
                            if (cmd.last)
                            begin
                                if (cfg.learn_en)
                                begin
                                    if (full)
                                    begin
                                        out_load  = 1'b1;
                                        ld_status = ST_FULL;
                                    end
                                end
                                else if (total_reg == '0)
                                begin
                                    out_load  = 1'b1;
                                    ld_status = ST_NO_DB;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            out_load = 1'b1;
                        end
                        OP_READ:
                        begin
                            if (!rd_ok)
                            begin
                                out_load  = 1'b1;
                                ld_status = ST_RANGE;
                            end
                        end
                        OP_WEIGHT:
                        begin
                            out_load  = 1'b1;
                            ld_status = cmd.w_ok ? ST_OK : ST_RANGE;
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            S_LEARN:
            begin
                if (lw_v_reg && lw_last_reg)
                begin
                    out_load = 1'b1;
                    ld_class = cfg.learn_class;
                end
            end
            S_VCOUNT:
            begin
                if (vote_last)
                begin
                    out_load = 1'b1;
                    ld_class = better ? cand : win_reg;
                end
            end
            S_RD_WAIT:
            begin
                out_load = 1'b1;
                ld_class = dbc_rd_reg;
                ld_feat  = dbf_rd_reg;
                ld_eor   = last_f;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            pos_reg        <= '0;
            f_reg          <= '0;
            addr_reg       <= '0;
            ent_reg        <= '0;
            issue_done_reg <= 1'b0;
            qvalid_reg     <= '0;
            wvalid_reg     <= '0;
            lw_v_reg       <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            vr_v_reg       <= 1'b0;
            vi_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg && t3_last_reg;
            vr_v_reg <= 1'b0;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        case (cmd.op)
                            OP_FEAT:
                            begin
                                if (q_we)
                                begin
                                    qvalid_reg[pos_reg[F_W-1:0]] <= 1'b1;
                                end
                                if (cmd.last)
                                begin
                                    pos_reg <= '0;
                                    if (cfg.learn_en)
                                    begin
                                        if (!full)
                                        begin
                                            state_reg      <= S_LEARN;
                                            f_reg          <= '0;
                                            addr_reg       <= learn_base;
                                            issue_done_reg <= 1'b0;
                                        end
                                    end
                                    else if (total_reg != '0)
                                    begin
                                        state_reg      <= S_SEARCH;
                                        f_reg          <= '0;
                                        addr_reg       <= '0;
                                        ent_reg        <= '0;
                                        issue_done_reg <= 1'b0;
                                    end
                                end
                                else if (q_we)
                                begin
                                    pos_reg <= pos_reg + POS_W'(1);
                                end
                            end
                            OP_CLEAR:
                            begin
                                total_reg <= '0;
                            end
                            OP_READ:
                            begin
                                if (rd_ok)
                                begin
                                    state_reg <= S_RD_ISSUE;
                                    f_reg     <= '0;
                                    addr_reg  <= rd_base;
                                    ent_reg   <= E_W'(cmd.index);
                                end
                            end
                            OP_WEIGHT:
                            begin
                                if (cmd.w_ok)
                                begin
                                    wvalid_reg[cmd.index[F_W-1:0]] <= 1'b1;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_LEARN:
                begin
                    if (!issue_done_reg)
                    begin
                        lw_v_reg <= 1'b1;
                        f_reg    <= last_f ? '0 : f_reg + F_W'(1);
                        addr_reg <= addr_reg + A_W'(1);
                        if (last_f)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        lw_v_reg <= 1'b0;
                    end
                    if (lw_v_reg && lw_last_reg)
                    begin
                        total_reg <= total_reg + T_W'(1);
                        state_reg <= S_IDLE;
                    end
                end
                S_SEARCH:
                begin
                    if (!issue_done_reg)
                    begin
                        v1_reg   <= 1'b1;
                        addr_reg <= addr_reg + A_W'(1);
                        if (last_f)
                        begin
                            f_reg   <= '0;
                            ent_reg <= ent_reg + E_W'(1);
                            if (last_ent)
                            begin
                                issue_done_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            f_reg <= f_reg + F_W'(1);
                        end
                    end
                    else if (!v1_reg && !v2_reg && !v3_reg && !v4_reg)
                    begin
                        state_reg <= S_VREAD;
                        vi_reg    <= '0;
                    end
                end
                S_VREAD:
                begin
                    if (vi_reg != cfg.k)
                    begin
                        vr_v_reg <= 1'b1;
                        vi_reg   <= vi_reg + K_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_VCOUNT;
                        vi_reg    <= '0;
                    end
                end
                S_VCOUNT:
                begin
                    if (vote_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        vi_reg <= vi_reg + K_W'(1);
                    end
                end
                S_RD_ISSUE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_RD_WAIT;
                    end
                end
                S_RD_WAIT:
                begin
                    if (last_f)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        f_reg     <= f_reg + F_W'(1);
                        addr_reg  <= addr_reg + A_W'(1);
                        state_reg <= S_RD_ISSUE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        lw_addr_reg <= addr_reg;
        lw_last_reg <= last_f;

        t1_last_reg <= last_f;
        t1_ent_reg  <= ent_reg;
        t2_last_reg <= t1_last_reg;
        t2_ent_reg  <= t1_ent_reg;
        t3_last_reg <= t2_last_reg;
        t3_ent_reg  <= t2_ent_reg;
        t4_ent_reg  <= t3_ent_reg;

        sq_reg   <= SQ_W'(mag) * SQ_W'(mag);
        w2_reg   <= wv_rd_reg ? w_rd_reg : WEIGHT_ONE;
        term_reg <= TERM_W'(sq_reg) * TERM_W'(w2_reg);

        if (search_start)
        begin
            acc_reg <= '0;
        end
        else if (v3_reg)
        begin
            if (t3_last_reg)
            begin
                acc_reg  <= '0;
                dist_reg <= acc_sum;
            end
            else
            begin
                acc_reg <= acc_sum;
            end
        end

        for (int i = 0; i < MAX_K; i++)
        begin
            if (search_start)
            begin
                best_dist_reg[i] <= DIST_TOP;
                best_ent_reg[i]  <= '0;
            end
            else if (v4_reg)
            begin
                best_dist_reg[i] <= ins_dist[i];
                best_ent_reg[i]  <= ins_ent[i];
            end
        end

        vr_idx_reg <= vi_reg[KI_W-1:0];
        if (vr_v_reg)
        begin
            vcls_reg[vr_idx_reg] <= dbc_rd_reg;
        end

        if (state_reg == S_VREAD)
        begin
            top_reg <= '0;
            win_reg <= '0;
        end
        else if (state_reg == S_VCOUNT && better)
        begin
            top_reg <= cnt;
            win_reg <= cand;
        end

        if (out_load)
        begin
            out_status_reg <= ld_status;
            out_class_reg  <= ld_class;
            out_feat_reg   <= ld_feat;
            out_eor_reg    <= ld_eor;
        end
    end

    // query vector and weight table
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qmem[pos_reg[F_W-1:0]] <= cmd.value;
        end
        if (w_we)
        begin
            wmem[cmd.index[F_W-1:0]] <= cmd.value;
        end
        q_rd_reg  <= qmem[f_reg];
        w_rd_reg  <= wmem[f_reg];
        qv_rd_reg <= qvalid_reg[f_reg];
        wv_rd_reg <= wvalid_reg[f_reg];
    end

    // database feature store
    always_ff @(posedge clk)
    begin
        if (lw_v_reg)
        begin
            dbf_mem[lw_addr_reg] <= q_eff;
        end
        dbf_rd_reg <= dbf_mem[addr_reg];
    end

    // database class store
    always_ff @(posedge clk)
    begin
        if (dbc_we)
        begin
            dbc_mem[total_reg[E_W-1:0]] <= cfg.learn_class;
        end
        dbc_rd_reg <= dbc_mem[dbc_raddr];
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign class_id      = out_class_reg;
    assign feature_value = out_feat_reg;
    assign end_of_run    = out_eor_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result overwrote a waiting result");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(NUM_FEATURES))
        else $error("element position out of range");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= T_W'(DB_DEPTH))
        else $error("entry total out of range");

    a_dist_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (state_reg == S_SEARCH))
        else $error("distance completed outside search");

    a_list_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VCOUNT) |-> (best_dist_reg[0] <= best_dist_reg[k_last[KI_W-1:0]]))
        else $error("k-best list not sorted");

endmodule

FILE: rtl/core/knn_classifier.sv
// knn classifier: feature elements queue up and are stored as they reach the engine; an
// input queue of 4 items lets the front keep accepting meanwhile. a search scans every
// entry on the single feature store port, then votes; learning copies the query into the
// store; a read back gives one result per element. no new item is taken until a run ends.
// reset (rst_n low, async) empties the database, sets all weights to 1.0, clears the
// query vector and sets neighbor_count to 1; no clearing pass is needed.
module knn_classifier
    import knn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,

    // input items
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ACT_W-1:0]         action,
    input  logic signed [VAL_W-1:0]  value,
    input  logic [IDX_W-1:0]         index,
    input  logic                     last,

    // result items
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic [CLS_W-1:0]         class_id,
    output logic signed [VAL_W-1:0]  feature_value,
    output logic                     end_of_run
);

    // register map, one word per register
    typedef enum logic [1:0] {
        REG_NEIGHBOR_COUNT,
        REG_LEARN_ENABLE,
        REG_LEARN_CLASS
    } reg_sel_t;

    logic [NC_W-1:0]  nc_reg;
    logic             le_reg;
    logic [CLS_W-1:0] lc_reg;
    logic             wr_en;
    logic [1:0]       sel;
    cfg_t             cfg;
    logic             pop;
    logic             cmd_valid;
    cmd_t             cmd;

    assign pready = 1'b1;
    assign sel    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= NC_W'(1);
            le_reg <= 1'b0;
            lc_reg <= '0;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_NEIGHBOR_COUNT: nc_reg <= pwdata[NC_W-1:0];
                REG_LEARN_ENABLE:   le_reg <= pwdata[0];
                REG_LEARN_CLASS:    lc_reg <= pwdata[CLS_W-1:0];
                default:            nc_reg <= nc_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_NEIGHBOR_COUNT: prdata = 32'(nc_reg);
            REG_LEARN_ENABLE:   prdata = 32'(le_reg);
            REG_LEARN_CLASS:    prdata = 32'(lc_reg);
            default:            prdata = '0;
        endcase
    end

    // k of zero acts as one, k above the list size is clamped
    always_comb
    begin
        if (nc_reg == '0)
        begin
            cfg.k = K_W'(1);
        end
        else if (32'(nc_reg) > MAX_K)
        begin
            cfg.k = K_W'(MAX_K);
        end
        else
        begin
            cfg.k = K_W'(nc_reg);
        end
        cfg.learn_en    = le_reg;
        cfg.learn_class = lc_reg;
    end

    // front: accepts and decodes items into the command queue
    knn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .index     (index),
        .last      (last),
        .pop       (pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // back: stores, searches, votes and drives the result register
    knn_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .class_id      (class_id),
        .feature_value (feature_value),
        .end_of_run    (end_of_run)
    );

endmodule

FILE: dv/knn_classifier_tb.sv
`timescale 1ns / 1ps

// Self-checking testbench for knn_classifier. Items go in on the valid/stall input
// channel, results come back on the output channel. A scoreboard keeps its own
// database, weights, query vector and k-best search and predicts every result.
// Registers are written over the APB-style port only while the block is idle.
// After a directed part come random phases, then a learn run and a final search.

import knn_pkg::*;

typedef struct {
    logic [STAT_W-1:0] st;
    logic [CLS_W-1:0]  cls;
    logic [VAL_W-1:0]  feat;
    bit                eor;
} knn_result_t;

class knn_scoreboard;
    logic [VAL_W-1:0] db_feat [DB_DEPTH][NUM_FEATURES];
    logic [CLS_W-1:0] db_cls [DB_DEPTH];
    int               total;
    logic [VAL_W-1:0] weight [NUM_FEATURES];
    logic [VAL_W-1:0] query [NUM_FEATURES];
    int               pos;
    int               k_reg;
    bit               learn_en;
    logic [CLS_W-1:0] learn_cls;
    knn_result_t      pending_q [$];

    function new();
        total = 0;
        pos = 0;
        k_reg = 1;
        learn_en = 0;
        learn_cls = 0;
        foreach (weight[i]) weight[i] = WEIGHT_ONE;
        foreach (query[i]) query[i] = '0;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
        if (idx == 0) k_reg = int'(val[4:0]);
        else if (idx == 1) learn_en = val[0];
        else if (idx == 2) learn_cls = val[6:0];
    endfunction

    function void push(logic [STAT_W-1:0] st, logic [CLS_W-1:0] cls,
                       logic [VAL_W-1:0] feat, bit eor);
        knn_result_t r;
        r.st = st;
        r.cls = cls;
        r.feat = feat;
        r.eor = eor;
        pending_q.push_back(r);
    endfunction

    // weighted nearest-neighbor search with early exit, then majority vote
    function logic [CLS_W-1:0] nearest_class();
        longint unsigned bd [MAX_K];
        int              be [MAX_K];
        int              votes [NUM_CLASSES];
        int              kk, p, win, top, d;
        longint unsigned s, a;
        kk = (k_reg == 0) ? 1 : (k_reg > MAX_K) ? MAX_K : k_reg;
        for (int i = 0; i < MAX_K; i++)
        begin
            bd[i] = 64'h00FF_FFFF_FFFF_FFFF;
            be[i] = 0;
        end
        for (int e = 0; e < total; e++)
        begin
            s = 0;
            for (int f = 0; f < NUM_FEATURES && s < bd[kk-1]; f++)
            begin
                d = int'($signed(query[f])) - int'($signed(db_feat[e][f]));
                a = longint'((d < 0) ? -d : d);
                s += a * a * 64'(weight[f]);
            end
            if (s < bd[kk-1])
            begin
                p = 0;
                while (p < kk && !(s < bd[p])) p++;
                for (int i = kk - 1; i > p; i--)
                begin
                    bd[i] = bd[i-1];
                    be[i] = be[i-1];
                end
                bd[p] = s;
                be[p] = e;
            end
        end
        foreach (votes[i]) votes[i] = 0;
        for (int i = 0; i < kk; i++)
            if (db_cls[be[i]] < NUM_CLASSES) votes[db_cls[be[i]]]++;
        win = 0;
        top = 0;
        for (int c = 0; c < NUM_CLASSES; c++)
            if (votes[c] > top)
            begin
                top = votes[c];
                win = c;
            end
        return CLS_W'(win);
    endfunction

    function void note_item(op_t op, logic [VAL_W-1:0] val, logic [IDX_W-1:0] idx, bit lst);
        case (op)
            OP_FEAT:
            begin
                if (pos < NUM_FEATURES)
                begin
                    query[pos] = val;
                    pos++;
                end
                if (lst)
                begin
                    pos = 0;
                    if (learn_en)
                    begin
                        if (total >= DB_DEPTH) push(ST_FULL, 0, 0, 1);
                        else
                        begin
                            foreach (query[f]) db_feat[total][f] = query[f];
                            db_cls[total] = learn_cls;
                            total++;
                            push(ST_OK, learn_cls, 0, 1);
                        end
                    end
                    else if (total == 0) push(ST_NO_DB, 0, 0, 1);
                    else push(ST_OK, nearest_class(), 0, 1);
                end
            end
            OP_CLEAR:
            begin
                total = 0;
                push(ST_OK, 0, 0, 1);
            end
            OP_READ:
            begin
                if (idx >= total) push(ST_RANGE, 0, 0, 1);
                else
                    for (int f = 0; f < NUM_FEATURES; f++)
                        push(ST_OK, db_cls[idx], db_feat[idx][f], f == NUM_FEATURES - 1);
            end
            default:
            begin
                if (idx >= NUM_FEATURES) push(ST_RANGE, 0, 0, 1);
                else
                begin
                    weight[idx] = val;
                    push(ST_OK, 0, 0, 1);
                end
            end
        endcase
    endfunction

    // empty string when the result matches the oldest expectation
    function string check_result(logic [STAT_W-1:0] st, logic [CLS_W-1:0] cls,
                                 logic [VAL_W-1:0] feat, logic eor);
        knn_result_t r;
        if (pending_q.size() == 0)
            return $sformatf("unexpected result st=%0d cls=%0d feat=%h", st, cls, feat);
        r = pending_q.pop_front();
        if (st !== r.st || cls !== r.cls || feat !== r.feat || eor !== r.eor)
            return $sformatf("result st=%0d cls=%0d feat=%h eor=%b, expected %0d %0d %h %b",
                             st, cls, feat, eor, r.st, r.cls, r.feat, r.eor);
        return "";
    endfunction
endclass

module knn_classifier_tb;

    localparam int REG_K     = 0;
    localparam int REG_LEARN = 1;
    localparam int REG_CLASS = 2;
    localparam int IDLE_LIMIT  = 40000;    // well beyond the longest search that this bench runs
    localparam int SETTLE_WAIT = 120;      // queued feature items may still be in the engine
    localparam int RANDOM_ITEMS = 430;
    localparam int FINAL_LEARNS = 20;

    logic                    clk;
    logic                    rst_n;
    logic                    psel, penable, pwrite;
    logic [3:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_stall;
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
    logic                    last;
    logic                    out_valid;
    logic                    out_stall;
    logic [STAT_W-1:0]       status;
    logic [CLS_W-1:0]        class_id;
    logic signed [VAL_W-1:0] feature_value;
    logic                    end_of_run;

    knn_scoreboard sb;
    int            errors;
    int            items_sent;
    int            idle_cycles;
    bit            calm;          // no idling on either side while set

    knn_classifier dut (.*);

    // clock, 12 ns period
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // signed q8.8 element: full range, small values, or the extremes
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return VAL_W'($urandom_range(0, 16'hFFFF));
            1: return 16'($urandom_range(0, 2047)) - 16'd1024;
            2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom_range(0, 255)) - 16'd128;
        endcase
    endfunction

    // result side: check every accepted result
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && out_valid && !out_stall)
        begin
            msg = sb.check_result(status, class_id, feature_value, end_of_run);
            if (msg != "") report(msg);
        end
    end

    // result side back-pressure
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = gap_len();
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clk);
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one item, held until accepted; entered and left at a falling edge
    task automatic send_item(op_t op, logic [VAL_W-1:0] val, logic [IDX_W-1:0] idx, bit lst);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid = 1'b1;
        action = op;
        value = val;
        index = idx;
        last = lst;
        do @(posedge clk); while (in_stall);
        sb.note_item(op, val, idx, lst);
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // feature vector of n elements, last flag on the final one
    task automatic send_vector(int n);
        for (int i = 0; i < n; i++)
            send_item(OP_FEAT, pick_value(), IDX_W'($urandom_range(0, 1023)), i == n - 1);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    // register write once the block is idle: setup cycle then access cycle
    task automatic write_reg(int idx, logic [31:0] val);
        wait_idle();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 4'(4 * idx);
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_mode(int k, bit learn, int cls);
        write_reg(REG_K, k);
        write_reg(REG_LEARN, 32'(learn));
        write_reg(REG_CLASS, cls);
    endtask

    initial
    begin
        int len, r;
        sb = new();
        errors = 0;
        items_sent = 0;
        idle_cycles = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        action = OP_FEAT;
        value = '0;
        index = '0;
        last = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty database, range errors, weights at the extremes
        send_item(OP_FEAT, 16'h7FFF, 10'h3FF, 1'b1);     // classify with no database
        send_item(OP_READ, 16'h0000, 10'd0, 1'b1);       // read of an empty database
        send_item(OP_WEIGHT, 16'hFFFF, 10'd40, 1'b0);    // weight index just out of range
        send_item(OP_WEIGHT, 16'hFFFF, 10'h3FF, 1'b1);
        send_item(OP_WEIGHT, 16'hFFFF, 10'd39, 1'b0);
        send_item(OP_WEIGHT, 16'h0000, 10'd0, 1'b0);
        send_item(OP_CLEAR, 16'hFFFF, 10'h3FF, 1'b1);

        // learn: a full vector, a short one (keeps older positions) and a surplus one
        set_mode(1, 1'b1, 99);
        send_vector(NUM_FEATURES);
        send_vector(3);
        write_reg(REG_CLASS, 127);
        send_vector(NUM_FEATURES + 5);
        send_item(OP_READ, 16'h0000, 10'd1, 1'b0);
        send_item(OP_READ, 16'h0000, 10'd3, 1'b0);       // at entry_total
        send_item(OP_READ, 16'h0000, 10'h3FF, 1'b0);

        // classify with k below, at and above its range
        set_mode(0, 1'b0, 0);
        send_vector(2);
        write_reg(REG_K, 16);
        send_vector(1);
        write_reg(REG_K, 31);
        send_vector(NUM_FEATURES);

        // random phases: small database, mostly well-formed vectors
        while (items_sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 3);
            set_mode($urandom_range(0, 31), r == 0, $urandom_range(0, 127));
            if (sb.total > 40)
                send_item(OP_CLEAR, pick_value(), IDX_W'($urandom_range(0, 1023)), 1'b0);
            for (int n = 0; n < 10; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    r = $urandom_range(0, 9);
                    len = (r < 6) ? $urandom_range(1, 8) :
                          (r < 9) ? NUM_FEATURES : $urandom_range(41, 45);
                    send_vector(len);
                end
                else if (r < 80)
                    send_item(OP_READ, pick_value(),
                              IDX_W'($urandom_range(0, 1) ? $urandom_range(0, sb.total + 1)
                                                          : $urandom_range(0, 1023)),
                              1'($urandom_range(0, 1)));
                else if (r < 93)
                    send_item(OP_WEIGHT, VAL_W'($urandom_range(0, 16'hFFFF)),
                              IDX_W'($urandom_range(0, 3) ? $urandom_range(0, 44)
                                                          : $urandom_range(0, 1023)),
                              1'($urandom_range(0, 1)));
                else if (r < 96)
                    send_item(OP_CLEAR, pick_value(), IDX_W'($urandom_range(0, 1023)),
                              1'($urandom_range(0, 1)));
                else
                    send_item(OP_FEAT, pick_value(), IDX_W'($urandom_range(0, 1023)), 1'b0);
            end
        end

        // add a few one-element entries with changing classes
        calm = 1'b0;
        set_mode(16, 1'b1, $urandom_range(0, 99));
        for (int n = 0; n < FINAL_LEARNS; n++)
        begin
            if ($urandom_range(0, 3) == 0) write_reg(REG_CLASS, $urandom_range(0, 127));
            send_vector(1);
        end

        // one search over the database as it stands
        set_mode(16, 1'b0, 0);
        send_vector(NUM_FEATURES);
        send_item(OP_CLEAR, 16'h0000, 10'd0, 1'b0);
        wait_idle();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/knn_pkg.sv
rtl/core/knn_front.sv
rtl/core/knn_back.sv
rtl/core/knn_classifier.sv
dv/knn_classifier_tb.sv
